// ----- design/nau_pkg.sv -----
// ----------------------------------------------------------------------------
// nau_pkg: shared types and constants for the activation unit
// Lane count, sample width, activation mode codes and the result item type.
// ----------------------------------------------------------------------------
`default_nettype none

package nau_pkg;

  localparam int unsigned LANES    = 4;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 3;

  // 0.1 in Q0.16
  localparam logic [13:0] LEAK_NUM = 14'd6554;

  // Logistic breakpoints and constants, Q8.8
  localparam logic [16:0] SIG_SAT   = 17'd1280;
  localparam logic [16:0] SIG_KNEE2 = 17'd608;
  localparam logic [16:0] SIG_KNEE1 = 17'd256;
  localparam logic [8:0]  SIG_ONE   = 9'd256;
  localparam logic [8:0]  SIG_OFS3  = 9'd216;
  localparam logic [8:0]  SIG_OFS2  = 9'd160;
  localparam logic [8:0]  SIG_OFS1  = 9'd128;

  typedef enum logic [1:0] {
    MODE_RELU     = 2'd0,
    MODE_LEAKY    = 2'd1,
    MODE_LINEAR   = 2'd2,
    MODE_LOGISTIC = 2'd3
  } mode_t;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [LANES-1:0][SAMPLE_W-1:0] result;
    logic [COUNT_W-1:0]             lanes;
    logic                           last;
  } item_t;

endpackage

`default_nettype wire

// ----- design/nau_lane.sv -----
// ----------------------------------------------------------------------------
// nau_lane: activation core for one lane
// Computes ReLU, leaky ReLU, linear or piecewise-linear logistic on one
// signed Q8.8 sample.
// ----------------------------------------------------------------------------
`default_nettype none

module nau_lane (
  input  wire nau_pkg::mode_t  mode,
  input  wire nau_pkg::sample_t x,
  output nau_pkg::sample_t     y
);

  logic signed [15:0] xs;
  logic signed [29:0] leak_prod;
  logic signed [13:0] leak_val;
  logic        [16:0] mag;
  logic        [8:0]  sig_pos;
  logic        [8:0]  sig_val;

  assign xs = $signed(x);

  // Arithmetic shift gives floor division, so small negative inputs give -1.
  assign leak_prod = 30'(xs) * $signed({1'b0, nau_pkg::LEAK_NUM});
  assign leak_val  = leak_prod[29:16];

  assign mag = xs[15] ? 17'(-$signed({xs[15], xs})) : {1'b0, x};

  always_comb begin
    if (mag >= nau_pkg::SIG_SAT) begin
      sig_pos = nau_pkg::SIG_ONE;
    end else if (mag >= nau_pkg::SIG_KNEE2) begin
      sig_pos = 9'(mag[10:5]) + nau_pkg::SIG_OFS3;
    end else if (mag >= nau_pkg::SIG_KNEE1) begin
      sig_pos = 9'(mag[10:3]) + nau_pkg::SIG_OFS2;
    end else begin
      sig_pos = 9'(mag[7:2]) + nau_pkg::SIG_OFS1;
    end
    sig_val = xs[15] ? (nau_pkg::SIG_ONE - sig_pos) : sig_pos;
  end

  always_comb begin
    case (mode)
      nau_pkg::MODE_RELU:     y = (xs > 16'sd0) ? x : '0;
      nau_pkg::MODE_LEAKY:    y = (xs > 16'sd0) ? x : 16'($signed(leak_val));
      nau_pkg::MODE_LINEAR:   y = x;
      nau_pkg::MODE_LOGISTIC: y = {7'd0, sig_val};
      default:                y = x;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/nau_merge.sv -----
// ----------------------------------------------------------------------------
// nau_merge: lane merge and output buffering
// Zeroes lanes beyond the valid count, packs the result item and holds it in
// an output register backed by a skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module nau_merge (
  input  wire                                                 clk,
  input  wire                                                 rst_n,
  input  wire                                                 in_valid,
  output logic                                                in_ready,
  input  wire [nau_pkg::LANES-1:0][nau_pkg::SAMPLE_W-1:0]     lane_res,
  input  wire [nau_pkg::COUNT_W-1:0]                          lanes_used,
  input  wire                                                 last_group,
  output logic                                                out_valid,
  input  wire                                                 out_ready,
  output nau_pkg::item_t                                      out_item
);

  nau_pkg::item_t new_item;
  nau_pkg::item_t main_r, main_nxt;
  nau_pkg::item_t skid_r, skid_nxt;
  logic           main_valid_r, main_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  logic           accept;

  always_comb begin
    for (int i = 0; i < nau_pkg::LANES; i++) begin
      new_item.result[i] = (lanes_used > nau_pkg::COUNT_W'(i)) ? lane_res[i] : '0;
    end
    new_item.lanes = lanes_used;
    new_item.last  = last_group;
  end

  assign in_ready  = ~skid_valid_r;
  assign accept    = in_valid & in_ready;
  assign out_valid = main_valid_r;
  assign out_item  = main_r;

  always_comb begin
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (~main_valid_r | out_ready) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = new_item;
        main_valid_nxt = accept;
      end
    end else if (accept) begin
      // Output is stalled: park the new transaction in the skid register.
      skid_nxt       = new_item;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

// ----- design/neural_activation_unit.sv -----
// An accepted transaction enters the output register at that clock edge if it is
// empty or being read, else the skid register; one per cycle while in_ready is high.
// The four lane cores are combinational; the one output register plus a skid
// register set the latency and let input continue while a result waits.
// Reset (rst_n low at a clock edge) empties both registers and sets the mode
// register to ReLU.
// ----------------------------------------------------------------------------
// neural_activation_unit: four-lane activation unit
// Applies the activation selected by the mode register to four Q8.8 samples
// per transaction and passes the lane count and last flag along.
// ----------------------------------------------------------------------------
`default_nettype none

module neural_activation_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [1:0]  cfg_wr_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [15:0] in_sample_a,
  input  wire  [15:0] in_sample_b,
  input  wire  [15:0] in_sample_c,
  input  wire  [15:0] in_sample_d,
  input  wire  [2:0]  in_lanes_used,
  input  wire         in_last_group,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [15:0] out_result_a,
  output logic [15:0] out_result_b,
  output logic [15:0] out_result_c,
  output logic [15:0] out_result_d,
  output logic [2:0]  out_lanes_out,
  output logic        out_last_out
);

  nau_pkg::mode_t  mode_r, mode_nxt;
  nau_pkg::sample_t [nau_pkg::LANES-1:0] samples;
  logic [nau_pkg::LANES-1:0][nau_pkg::SAMPLE_W-1:0] lane_res;
  nau_pkg::item_t  out_item;

  assign mode_nxt = cfg_wr_en ? nau_pkg::mode_t'(cfg_wr_data) : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= nau_pkg::MODE_RELU;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign samples[0] = in_sample_a;
  assign samples[1] = in_sample_b;
  assign samples[2] = in_sample_c;
  assign samples[3] = in_sample_d;

  for (genvar g = 0; g < nau_pkg::LANES; g++) begin : g_lane
    nau_lane u_lane (
      .mode (mode_r),
      .x    (samples[g]),
      .y    (lane_res[g])
    );
  end

  nau_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .lane_res   (lane_res),
    .lanes_used (in_lanes_used),
    .last_group (in_last_group),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  assign out_result_a  = out_item.result[0];
  assign out_result_b  = out_item.result[1];
  assign out_result_c  = out_item.result[2];
  assign out_result_d  = out_item.result[3];
  assign out_lanes_out = out_item.lanes;
  assign out_last_out  = out_item.last;

endmodule

`default_nettype wire

// ----- design/nau_checker.sv -----
// ----------------------------------------------------------------------------
// nau_checker: port-level checks for the activation unit
// Watches handshakes and result contents on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module nau_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [15:0] out_result_a,
  input wire [15:0] out_result_b,
  input wire [15:0] out_result_c,
  input wire [15:0] out_result_d,
  input wire [2:0]  out_lanes_out,
  input wire        out_last_out
);

  // A stalled result transaction stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result_a) && $stable(out_result_b)
      && $stable(out_result_c) && $stable(out_result_d)
      && $stable(out_lanes_out) && $stable(out_last_out))
    else $error("result payload changed while stalled");

  // Input back-pressure only happens while a result is held.
  a_ready_backed: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result pending");

  // Lanes beyond a valid count of one read as zero.
  a_lane_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_lanes_out == 3'd1) |->
      out_result_b == 16'd0 && out_result_c == 16'd0 && out_result_d == 16'd0)
    else $error("unused lane result not zero");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("buffers not empty after reset");

endmodule

bind neural_activation_unit nau_checker u_nau_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_result_a  (out_result_a),
  .out_result_b  (out_result_b),
  .out_result_c  (out_result_c),
  .out_result_d  (out_result_d),
  .out_lanes_out (out_lanes_out),
  .out_last_out  (out_last_out)
);

`default_nettype wire

// ----- tb/tb_neural_activation_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_neural_activation_unit: self-checking testbench for the activation unit
// Drives groups of four Q8.8 samples under every activation mode, predicts
// each result from an independent fixed-point activation function and checks
// every output transaction field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_neural_activation_unit;

  localparam int unsigned PHASE_ITEMS  = 240;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned HOLD_TRIGGER = 604;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [nau_pkg::LANES-1:0][nau_pkg::SAMPLE_W-1:0] sample;
    logic [nau_pkg::COUNT_W-1:0]                      lanes;
    logic                                             last;
  } group_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_sample_a = '0;
  logic [15:0] in_sample_b = '0;
  logic [15:0] in_sample_c = '0;
  logic [15:0] in_sample_d = '0;
  logic [2:0]  in_lanes_used = '0;
  logic        in_last_group = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_result_a;
  logic [15:0] out_result_b;
  logic [15:0] out_result_c;
  logic [15:0] out_result_d;
  logic [2:0]  out_lanes_out;
  logic        out_last_out;

  group_t          group_q[$];
  nau_pkg::item_t  activated_q[$];
  group_t          group_on_bus;
  nau_pkg::mode_t  cur_mode = nau_pkg::MODE_RELU;
  bit              idle_en = 1'b0;
  logic            hold_off = 1'b0;
  int unsigned     send_gap = 0;
  int unsigned     rcv_gap = 0;
  int unsigned     accepted_cnt = 0;
  int unsigned     result_cnt = 0;
  int unsigned     input_stall_cycles = 0;
  int unsigned     mode_writes = 0;
  int unsigned     errors = 0;

  neural_activation_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_a  (in_sample_a),
    .in_sample_b  (in_sample_b),
    .in_sample_c  (in_sample_c),
    .in_sample_d  (in_sample_d),
    .in_lanes_used(in_lanes_used),
    .in_last_group(in_last_group),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_result_a (out_result_a),
    .out_result_b (out_result_b),
    .out_result_c (out_result_c),
    .out_result_d (out_result_d),
    .out_lanes_out(out_lanes_out),
    .out_last_out (out_last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fixed-point activation of one Q8.8 sample.
  function automatic logic [15:0] activate(nau_pkg::mode_t m, logic [15:0] raw);
    int x;
    int mag;
    int y;
    x = int'($signed(raw));
    case (m)
      nau_pkg::MODE_RELU:   y = (x > 0) ? x : 0;
      // Arithmetic shift of the exact product rounds toward minus infinity.
      nau_pkg::MODE_LEAKY:  y = (x > 0) ? x : ((x * int'(nau_pkg::LEAK_NUM)) >>> 16);
      nau_pkg::MODE_LINEAR: y = x;
      default: begin
        mag = (x < 0) ? -x : x;
        if (mag >= int'(nau_pkg::SIG_SAT))
          y = int'(nau_pkg::SIG_ONE);
        else if (mag >= int'(nau_pkg::SIG_KNEE2))
          y = mag / 32 + int'(nau_pkg::SIG_OFS3);
        else if (mag >= int'(nau_pkg::SIG_KNEE1))
          y = mag / 8 + int'(nau_pkg::SIG_OFS2);
        else
          y = mag / 4 + int'(nau_pkg::SIG_OFS1);
        if (x < 0)
          y = int'(nau_pkg::SIG_ONE) - y;
      end
    endcase
    return 16'(y);
  endfunction

  function automatic nau_pkg::item_t activate_group(nau_pkg::mode_t m, group_t g);
    nau_pkg::item_t r;
    for (int i = 0; i < nau_pkg::LANES; i++)
      r.result[i] = (i < g.lanes) ? activate(m, g.sample[i]) : '0;
    r.lanes = g.lanes;
    r.last  = g.last;
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 65)
      return 0;
    if (p < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Samples are biased toward the logistic breakpoints and the range limits.
  function automatic logic [15:0] rand_sample();
    int unsigned pick;
    int mag;
    pick = $urandom_range(0, 9);
    if (pick < 3)
      return 16'($urandom);
    if (pick < 8)
      mag = $urandom_range(0, 1400);
    else if (pick == 8)
      mag = 32768 - $urandom_range(0, 15);
    else
      mag = $urandom_range(0, 20);
    return ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic group_t rand_group();
    group_t g;
    for (int i = 0; i < nau_pkg::LANES; i++)
      g.sample[i] = rand_sample();
    g.lanes = ($urandom_range(0, 9) < 6) ? 3'(nau_pkg::LANES) : 3'($urandom_range(0, 7));
    g.last  = ($urandom_range(0, 3) == 0);
    return g;
  endfunction

  task automatic queue_group(int a, int b, int c, int d, int lanes, bit last);
    group_t g;
    g.sample[0] = 16'(a);
    g.sample[1] = 16'(b);
    g.sample[2] = 16'(c);
    g.sample[3] = 16'(d);
    g.lanes = 3'(lanes);
    g.last  = last;
    group_q.push_back(g);
  endtask

  task automatic write_mode(nau_pkg::mode_t m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_mode = m;
    mode_writes++;
  endtask

  // Wait until every queued group has been sent and every result has arrived.
  task automatic settle();
    wait (group_q.size() == 0 && !in_valid && activated_q.size() == 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_directed();
    @(negedge clk);
    idle_en = 1'b0;
    queue_group(0, 1, -1, 32767, 4, 1'b0);
    queue_group(-32768, 255, 256, -256, 7, 1'b1);
    queue_group(-255, 607, 608, -608, 5, 1'b0);
    queue_group(-607, 1279, 1280, -1280, 6, 1'b1);
    // Lane count three leaves lane d zeroed; small negatives check leaky rounding.
    queue_group(-1279, -5, -10, 100, 3, 1'b0);
    queue_group(1234, -1234, 77, -77, 0, 1'b1);
    settle();
  endtask

  task automatic run_random(nau_pkg::mode_t m, bit gaps);
    write_mode(m);
    @(negedge clk);
    idle_en = gaps;
    repeat (PHASE_ITEMS) group_q.push_back(rand_group());
    settle();
  endtask

  // Sender: holds each group until it is accepted, then predicts its result.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        activated_q.push_back(activate_group(cur_mode, group_on_bus));
        accepted_cnt++;
      end else if (in_valid) begin
        input_stall_cycles++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (group_q.size() != 0) begin
          group_on_bus = group_q.pop_front();
          in_sample_a   <= group_on_bus.sample[0];
          in_sample_b   <= group_on_bus.sample[1];
          in_sample_c   <= group_on_bus.sample[2];
          in_sample_d   <= group_on_bus.sample[3];
          in_lanes_used <= group_on_bus.lanes;
          in_last_group <= group_on_bus.last;
          in_valid      <= 1'b1;
          send_gap = idle_en ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result and throttles out_ready.
  always @(posedge clk) begin
    nau_pkg::item_t got;
    nau_pkg::item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.result[0] = out_result_a;
        got.result[1] = out_result_b;
        got.result[2] = out_result_c;
        got.result[3] = out_result_d;
        got.lanes     = out_lanes_out;
        got.last      = out_last_out;
        result_cnt++;
        if (activated_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("ERROR: result %0d arrived with none outstanding", result_cnt);
        end else begin
          want = activated_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("ERROR: result %0d mismatch", result_cnt);
              $display("  expected lanes %h %h %h %h count %0d last %0b",
                       want.result[0], want.result[1], want.result[2], want.result[3],
                       want.lanes, want.last);
              $display("  actual   lanes %h %h %h %h count %0d last %0b",
                       got.result[0], got.result[1], got.result[2], got.result[3],
                       got.lanes, got.last);
            end
          end
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (rcv_gap != 0) begin
        rcv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rcv_gap = idle_en ? idle_len() : 0;
      end
    end
  end

  // Long receiver stall in the middle of a phase so the unit fills up and
  // pushes back on its input while the sender keeps offering.
  initial begin
    wait (accepted_cnt >= HOLD_TRIGGER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The first directed pass runs with the mode left at its reset value.
    run_directed();
    write_mode(nau_pkg::MODE_LEAKY);
    run_directed();
    write_mode(nau_pkg::MODE_LINEAR);
    run_directed();
    write_mode(nau_pkg::MODE_LOGISTIC);
    run_directed();

    run_random(nau_pkg::MODE_LOGISTIC, 1'b1);
    run_random(nau_pkg::MODE_LEAKY, 1'b0);
    run_random(nau_pkg::MODE_RELU, 1'b1);
    run_random(nau_pkg::MODE_LINEAR, 1'b0);
    run_random(nau_pkg::MODE_LOGISTIC, 1'b1);
    run_random(nau_pkg::MODE_LEAKY, 1'b1);
    run_random(nau_pkg::mode_t'($urandom_range(0, 3)), 1'b0);
    run_random(nau_pkg::mode_t'($urandom_range(0, 3)), 1'b1);

    $display("Sent %0d groups and checked %0d results over %0d mode writes.",
             accepted_cnt, result_cnt, mode_writes);
    $display("Input was held back for %0d cycles; %0d errors found.",
             input_stall_cycles, errors);
    if (errors == 0 && activated_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/nau_pkg.sv
design/nau_lane.sv
design/nau_merge.sv
design/neural_activation_unit.sv
design/nau_checker.sv
tb/tb_neural_activation_unit.sv
